// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
// Used by bba_ctrl, bba_dp and buddy_block_allocator.
`default_nettype none
package bba_pkg;

    localparam int TOTAL_WORDS = 32;
    localparam int LG_TOTAL    = 5;
    localparam int NODE_W      = LG_TOTAL + 1;
    localparam int TREE_DEPTH  = 2 * TOTAL_WORDS;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADSIZE = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_WALK,
        S_ALLOC_BACK,
        S_SPLIT,
        S_FREE_WALK,
        S_MERGE,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DOWN_LEFT,
        DP_UP,
        DP_SIBLING,
        DP_SPLIT_MARK,
        DP_MARK_DONE,
        DP_FREE_DOWN,
        DP_CLEAR,
        DP_CLEAR_UP,
        DP_ERR
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] err_code;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_free;
        logic size_bad;
        logic node_set;
        logic node_used;
        logic fits;
        logic child_fits;
        logic at_size;
        logic is_root;
        logic is_right;
        logic off_match;
        logic sib_free;
    } t_dp_status;

    // log2 of the rounded word count for a byte request
    function automatic logic [2:0] size_log2(input logic [7:0] bytes);
        logic [8:0] words;
        logic [2:0] lg;
        words = ({1'b0, bytes} + 9'd3) >> 2;
        lg = 3'd0;
        for (int j = 0; j < 7; j++) begin
            if (words > (9'd1 << j)) begin
                lg = 3'(j + 1);
            end
        end
        return lg;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bba_dp.sv =====
// Datapath: node tree bits, walk pointer and result registers.
// Depends on bba_pkg; driven by bba_ctrl commands.
`default_nettype none
module bba_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire bba_pkg::t_dp_cmd i_cmd,
    input  wire                 i_command,
    input  wire  [7:0]          i_request_bytes,
    input  wire  [4:0]          i_free_offset,
    output bba_pkg::t_dp_status o_status_flags,
    output logic [1:0]          o_status,
    output logic [4:0]          o_block_offset,
    output logic [5:0]          o_block_words
);
    import bba_pkg::*;

    // tree bits kept in sibling pairs: bit b of entry p is node 2p+b
    logic [TOTAL_WORDS-1:0][1:0] r_pair;
    logic [NODE_W-1:0]     r_node;
    logic [2:0]            r_lg;
    logic [2:0]            r_lgk;
    logic                  r_cmd;
    logic                  r_bad;
    logic [4:0]            r_off;
    logic [1:0]            r_res_status;
    logic [4:0]            r_res_off;
    logic [5:0]            r_res_words;

    logic [NODE_W-1:0]     left_child;
    logic [NODE_W-1:0]     parent;
    logic [NODE_W+LG_TOTAL-1:0] node_shift;
    logic [4:0]            node_off;
    logic [2:0]            req_lg;
    logic [LG_TOTAL-1:0]   par_idx;
    logic [LG_TOTAL-1:0]   self_idx;
    logic [LG_TOTAL-1:0]   gpar_idx;
    logic [1:0]            par_pair;
    logic [1:0]            self_pair;

    assign left_child = {r_node[NODE_W-2:0], 1'b0};
    assign parent     = r_node >> 1;
    assign node_shift = {{LG_TOTAL{1'b0}}, r_node} << r_lg;
    assign node_off   = node_shift[4:0];
    assign req_lg     = size_log2(i_request_bytes);

    // pair holding this node and its sibling, and pair holding its children
    assign par_idx   = r_node[NODE_W-1:1];
    assign self_idx  = r_node[LG_TOTAL-1:0];
    assign gpar_idx  = {1'b0, r_node[NODE_W-1:2]};
    assign par_pair  = r_pair[par_idx];
    assign self_pair = r_pair[self_idx];

    always_comb begin
        o_status_flags.cmd_free   = r_cmd;
        o_status_flags.size_bad   = r_bad;
        o_status_flags.node_set   = par_pair[r_node[0]];
        o_status_flags.node_used  = (r_lg == 3'd0) || (self_pair == 2'b00);
        o_status_flags.fits       = r_lg >= r_lgk;
        o_status_flags.child_fits = r_lg > r_lgk;
        o_status_flags.at_size    = r_lg == r_lgk;
        o_status_flags.is_root    = r_node == 6'd1;
        o_status_flags.is_right   = r_node[0];
        o_status_flags.off_match  = node_off == r_off;
        o_status_flags.sib_free   = !par_pair[~r_node[0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= '0;
        end else begin
            case (i_cmd.op)
                DP_SPLIT_MARK, DP_MARK_DONE: r_pair[par_idx][r_node[0]] <= 1'b1;
                DP_CLEAR:                    r_pair[par_idx][r_node[0]] <= 1'b0;
                DP_CLEAR_UP:                 r_pair[gpar_idx][r_node[1]] <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_node <= 6'd1;
                r_lg   <= 3'(LG_TOTAL);
                r_lgk  <= req_lg;
                r_cmd  <= i_command;
                r_bad  <= (i_request_bytes == 8'd0) || (req_lg > 3'(LG_TOTAL));
                r_off  <= i_free_offset;
            end
            DP_DOWN_LEFT, DP_SPLIT_MARK: begin
                r_node <= left_child;
                r_lg   <= r_lg - 3'd1;
            end
            DP_UP, DP_CLEAR_UP: begin
                r_node <= parent;
                r_lg   <= r_lg + 3'd1;
            end
            DP_SIBLING: r_node <= r_node + 6'd1;
            DP_FREE_DOWN: begin
                r_node <= left_child | {5'd0, r_off[r_lg - 3'd1]};
                r_lg   <= r_lg - 3'd1;
            end
            DP_MARK_DONE, DP_CLEAR: begin
                r_res_status <= ST_OK;
                r_res_off    <= node_off;
                r_res_words  <= 6'd1 << r_lg;
            end
            DP_ERR: begin
                r_res_status <= i_cmd.err_code;
                r_res_off    <= '0;
                r_res_words  <= '0;
            end
            default: ;
        endcase
    end

    assign o_status       = r_res_status;
    assign o_block_offset = r_res_off;
    assign o_block_words  = r_res_words;

endmodule
`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
// Controller state machine: sequences tree search, split, free walk and merge.
// Depends on bba_pkg; commands bba_dp.
`default_nettype none
module bba_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire                 i_stall,
    input  wire bba_pkg::t_dp_status i_flags,
    output bba_pkg::t_dp_cmd    o_cmd
);
    import bba_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_ALLOC_WALK;
                end
            end
            S_ALLOC_WALK: begin
                if (i_flags.cmd_free) begin
                    n_state = S_FREE_WALK;
                end else if (i_flags.size_bad) begin
                    n_state = S_DONE;
                end else if (!i_flags.node_set) begin
                    n_state = i_flags.fits ? S_SPLIT : S_ALLOC_BACK;
                end else if (i_flags.node_used || !i_flags.child_fits) begin
                    n_state = S_ALLOC_BACK;
                end
            end
            S_ALLOC_BACK: begin
                if (i_flags.is_root) begin
                    n_state = S_DONE;
                end else if (!i_flags.is_right) begin
                    n_state = S_ALLOC_WALK;
                end
            end
            S_SPLIT: begin
                if (i_flags.at_size) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_WALK: begin
                if (!i_flags.node_set) begin
                    n_state = S_DONE;
                end else if (i_flags.node_used) begin
                    n_state = i_flags.off_match ? S_MERGE : S_DONE;
                end
            end
            S_MERGE: begin
                if (i_flags.is_root || !i_flags.sib_free) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = DP_NOP;
        o_cmd.err_code = ST_OK;
        o_stall        = r_state != S_IDLE;
        o_valid        = r_state == S_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                end
            end
            S_ALLOC_WALK: begin
                if (i_flags.cmd_free) begin
                    o_cmd.op = DP_NOP;
                end else if (i_flags.size_bad) begin
                    o_cmd.op       = DP_ERR;
                    o_cmd.err_code = ST_BADSIZE;
                end else if (i_flags.node_set && !i_flags.node_used &&
                             i_flags.child_fits) begin
                    o_cmd.op = DP_DOWN_LEFT;
                end
            end
            S_ALLOC_BACK: begin
                if (i_flags.is_root) begin
                    o_cmd.op       = DP_ERR;
                    o_cmd.err_code = ST_NOSPACE;
                end else if (i_flags.is_right) begin
                    o_cmd.op = DP_UP;
                end else begin
                    o_cmd.op = DP_SIBLING;
                end
            end
            S_SPLIT: begin
                o_cmd.op = i_flags.at_size ? DP_MARK_DONE : DP_SPLIT_MARK;
            end
            S_FREE_WALK: begin
                if (!i_flags.node_set ||
                    (i_flags.node_used && !i_flags.off_match)) begin
                    o_cmd.op       = DP_ERR;
                    o_cmd.err_code = ST_BADFREE;
                end else if (i_flags.node_used) begin
                    o_cmd.op = DP_CLEAR;
                end else begin
                    o_cmd.op = DP_FREE_DOWN;
                end
            end
            S_MERGE: begin
                if (!i_flags.is_root && i_flags.sib_free) begin
                    o_cmd.op = DP_CLEAR_UP;
                end
            end
            default: ;
        endcase
    end

    // busy from the edge a request is taken until its result leaves
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while not marked busy");
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result presented twice");

endmodule
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator over a 32-word region.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
// Input channel: i_valid / o_stall with i_command, i_request_bytes and
// i_free_offset. Output channel: o_valid / i_stall with o_status,
// o_block_offset and o_block_words; one result per request.
// One request is in flight at a time; o_stall is high from the accepting
// edge until the result has been taken.
// Allocate: the request is loaded, then the leftmost-first search visits
// tree nodes (down, sibling and up moves), then the free block found is
// split level by level, then the result. Bad sizes are reported without a
// search; a search runs over the 63-node tree.
// Free: the request is loaded, then the walk goes down level by level (up
// to 6 levels), then merges level by level, then the result.
// A stalled result is held in its output registers until taken.
// Reset (synchronous, active low) clears the tree so the whole region is one
// free block and drops any request in progress.
`default_nettype none
module buddy_block_allocator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire        i_command,
    input  wire  [7:0] i_request_bytes,
    input  wire  [4:0] i_free_offset,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [1:0] o_status,
    output logic [4:0] o_block_offset,
    output logic [5:0] o_block_words
);
    import bba_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_flags;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_flags (dp_flags),
        .o_cmd   (dp_cmd)
    );

    bba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_command       (i_command),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .o_status_flags  (dp_flags),
        .o_status        (o_status),
        .o_block_offset  (o_block_offset),
        .o_block_words   (o_block_words)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_block_offset == 5'd0 && o_block_words == 6'd0))
        else $error("error result carries a block");
    a_ok_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> $onehot(o_block_words))
        else $error("block size not a power of two");
    a_ok_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |->
            ((o_block_offset & (o_block_words[4:0] - 5'd1)) == 5'd0))
        else $error("block offset not aligned to its size");

endmodule
`default_nettype wire
